FILE: rtl/core/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types, constants and knot tables for the spectrum colormap unit.
// ----------------------------------------------------------------------------
package scl_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int SCALE_W  = 32;
    localparam int CHAN_W   = 8;

    // Magnitude of a non-negative sample times the scale
    localparam int PROD_W = (SAMPLE_W - 1) + SCALE_W;

    // Default fraction bits of sample, scale and normalized value
    localparam int DEFAULT_FRAC_BITS = 16;

    // Scale register reset: 1.0 in Q16.16
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    // Knot tables
    localparam int KNOT_COUNT = 11;
    localparam int LAST_KNOT  = KNOT_COUNT - 1;
    localparam int KNOT_IDX_W = $clog2(KNOT_COUNT);

    localparam logic [CHAN_W-1:0] ALPHA_VALUE = 8'd96;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Channel order inside an rgb_t
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_COUNT = 3;

    typedef logic [CH_COUNT-1:0][CHAN_W-1:0] rgb_t;

    // Item handed from front to back
    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic              black;
        logic              last;
    } front_item_t;

    // Knot colors, indexed by knot number
    function automatic rgb_t knot_rgb(input logic [KNOT_IDX_W-1:0] idx);
        rgb_t c;
        c = '0;
        unique case (idx)
            4'd0:    begin c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd128; end
            4'd1:    begin c[CH_RED] = 8'd38;  c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd106; end
            4'd2:    begin c[CH_RED] = 8'd76;  c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd211; end
            4'd3:    begin c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd230; end
            4'd4:    begin c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd140; c[CH_BLUE] = 8'd120; end
            4'd5:    begin c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd180; c[CH_BLUE] = 8'd60;  end
            4'd6:    begin c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd250; c[CH_BLUE] = 8'd0;   end
            4'd7:    begin c[CH_RED] = 8'd60;  c[CH_GREEN] = 8'd180; c[CH_BLUE] = 8'd0;   end
            4'd8:    begin c[CH_RED] = 8'd120; c[CH_GREEN] = 8'd120; c[CH_BLUE] = 8'd0;   end
            4'd9:    begin c[CH_RED] = 8'd180; c[CH_GREEN] = 8'd60;  c[CH_BLUE] = 8'd0;   end
            4'd10:   begin c[CH_RED] = 8'd255; c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd0;   end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/scl_channels.sv
// ----------------------------------------------------------------------------
// scl_channels
// Valid/ready channels of the colormap unit: samples, colors, configuration.
// ----------------------------------------------------------------------------
interface scl_sample_if
    import scl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_in;

    modport source (output valid, output sample_value, output last_in, input ready);
    modport sink   (input valid, input sample_value, input last_in, output ready);
endinterface

interface scl_color_if
    import scl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last_out;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output last_out, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input last_out, output ready);
endinterface

interface scl_cfg_if
    import scl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] inv_max_scale;

    modport source (output valid, output inv_max_scale, input ready);
    modport sink   (input valid, input inv_max_scale, output ready);
endinterface

FILE: rtl/core/spectrum_colormap_lerp_unit.sv
// ----------------------------------------------------------------------------
// spectrum_colormap_lerp_unit
// Maps a signed fixed-point sample to an RGBA color through an 11-knot table.
// Path: a sample passes through the front product stage, the queue, the index
// stage, the multiply stage and the output register.
// Throughput: one item per cycle while the colors output is ready; the 31x32 product is formed in the front stage.
// Reset: valid bits and queue clear, scale register returns to 1.0.
// ----------------------------------------------------------------------------
module spectrum_colormap_lerp_unit
    import scl_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    scl_sample_if.sink  samples,
    scl_color_if.source colors,
    scl_cfg_if.sink     cfg
);

    // Scale register
    logic [SCALE_W-1:0] scale_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg.valid && cfg.ready)
            scale_reg <= cfg.inv_max_scale;
    end

    front_item_t front_item;
    logic        front_valid;
    logic        front_ready;
    front_item_t back_item;
    logic        back_valid;
    logic        back_ready;

    scl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .inv_max_scale (scale_reg),
        .item          (front_item),
        .item_valid    (front_valid),
        .item_ready    (front_ready)
    );

    scl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    scl_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .colors     (colors)
    );

endmodule

FILE: rtl/core/scl_front.sv
// ----------------------------------------------------------------------------
// scl_front
// Accepts samples, classifies negative ones and forms the scaled product.
// ----------------------------------------------------------------------------
module scl_front
    import scl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    scl_sample_if.sink         samples,
    input  logic [SCALE_W-1:0] inv_max_scale,
    output front_item_t        item,
    output logic               item_valid,
    input  logic               item_ready
);

    logic        valid_reg;
    logic        valid_next;
    front_item_t item_reg;
    front_item_t item_next;
    logic        load;
    logic        negative;
    logic [SAMPLE_W-2:0] mag;

    assign samples.ready = !valid_reg || item_ready;
    assign load          = samples.valid && samples.ready;

    // Classify: negative with nonzero scale is black; negative with zero scale maps to 0
    always_comb
    begin
        negative          = samples.sample_value[SAMPLE_W-1];
        mag               = negative ? '0 : samples.sample_value[SAMPLE_W-2:0];
        item_next.black   = negative && (inv_max_scale != '0);
        item_next.last    = samples.last_in;
        item_next.product = PROD_W'(mag) * PROD_W'(inv_max_scale);
    end

    // Stage valid
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

FILE: rtl/core/scl_queue.sv
// ----------------------------------------------------------------------------
// scl_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module scl_queue
    import scl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  front_item_t push_item,
    input  logic        push_valid,
    output logic        push_ready,
    output front_item_t pop_item,
    output logic        pop_valid,
    input  logic        pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_item_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/core/scl_back.sv
// ----------------------------------------------------------------------------
// scl_back
// Splits the normalized value into knot index and fraction, interpolates
// red, green and blue between knots and holds the result in an output stage.
// ----------------------------------------------------------------------------
module scl_back
    import scl_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  front_item_t item,
    input  logic        item_valid,
    output logic        item_ready,
    scl_color_if.source colors
);

    localparam int NORM_W   = PROD_W - FRAC_BITS;
    localparam int SCALED_W = NORM_W + 4;
    localparam int IDX_W    = SCALED_W - FRAC_BITS;
    localparam int MUL_W    = FRAC_BITS + CHAN_W;

    // Pipeline enables: a stage moves when it is empty or the next one moves
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic en_out;
    logic en_s2;
    logic en_s1;

    assign en_out     = !out_valid_reg || colors.ready;
    assign en_s2      = !s2_valid_reg || en_out;
    assign en_s1      = !s1_valid_reg || en_s2;
    assign item_ready = en_s1;

    // Stage 1: times ten, knot index, fraction
    logic [NORM_W-1:0]     norm;
    logic [SCALED_W-1:0]   scaled;
    logic [IDX_W-1:0]      idx_full;
    logic [KNOT_IDX_W-1:0] s1_idx_reg;
    logic [FRAC_BITS-1:0]  s1_frac_reg;
    logic                  s1_sat_reg;
    logic                  s1_black_reg;
    logic                  s1_last_reg;

    always_comb
    begin
        norm     = item.product[PROD_W-1:FRAC_BITS];
        scaled   = SCALED_W'({norm, 3'b000}) + SCALED_W'({norm, 1'b0});
        idx_full = scaled[SCALED_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_idx_reg   <= idx_full[KNOT_IDX_W-1:0];
            s1_frac_reg  <= scaled[FRAC_BITS-1:0];
            s1_sat_reg   <= (idx_full >= IDX_W'(LAST_KNOT));
            s1_black_reg <= item.black;
            s1_last_reg  <= item.last;
        end
    end

    // Stage 2: knot lookup, signed distance, fraction times distance
    rgb_t                                 lo_knot;
    rgb_t                                 hi_knot;
    logic [CH_COUNT-1:0]                  down;
    logic [CH_COUNT-1:0][CHAN_W-1:0]      diff;
    rgb_t                                 s2_lo_reg;
    logic [CH_COUNT-1:0]                  s2_down_reg;
    logic [CH_COUNT-1:0][MUL_W-1:0]       s2_mul_reg;
    logic                                 s2_sat_reg;
    logic                                 s2_black_reg;
    logic                                 s2_last_reg;

    always_comb
    begin
        lo_knot = knot_rgb(s1_idx_reg);
        hi_knot = knot_rgb(KNOT_IDX_W'(s1_idx_reg + 1'b1));
        for (int c = 0; c < CH_COUNT; c++)
        begin
            down[c] = hi_knot[c] < lo_knot[c];
            diff[c] = down[c] ? (lo_knot[c] - hi_knot[c]) : (hi_knot[c] - lo_knot[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s2)
        begin
            for (int c = 0; c < CH_COUNT; c++)
                s2_mul_reg[c] <= MUL_W'(s1_frac_reg) * MUL_W'(diff[c]);
            s2_lo_reg    <= lo_knot;
            s2_down_reg  <= down;
            s2_sat_reg   <= s1_sat_reg;
            s2_black_reg <= s1_black_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Stage 3: apply the truncated step, saturate, blank negatives
    rgb_t rgb_next;
    rgb_t out_rgb_reg;
    logic out_last_reg;
    logic [CHAN_W-1:0] step;

    always_comb
    begin
        rgb_next = '0;
        step     = '0;
        for (int c = 0; c < CH_COUNT; c++)
        begin
            step        = s2_mul_reg[c][MUL_W-1:FRAC_BITS];
            rgb_next[c] = s2_down_reg[c] ? (s2_lo_reg[c] - step) : (s2_lo_reg[c] + step);
        end
        priority if (s2_black_reg)
            rgb_next = '0;
        else if (s2_sat_reg)
            rgb_next = knot_rgb(KNOT_IDX_W'(LAST_KNOT));
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_rgb_reg  <= rgb_next;
            out_last_reg <= s2_last_reg;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
                s1_valid_reg <= item_valid;
            if (en_s2)
                s2_valid_reg <= s1_valid_reg;
            if (en_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign colors.valid    = out_valid_reg;
    assign colors.red      = out_rgb_reg[CH_RED];
    assign colors.green    = out_rgb_reg[CH_GREEN];
    assign colors.blue     = out_rgb_reg[CH_BLUE];
    assign colors.alpha    = ALPHA_VALUE;
    assign colors.last_out = out_last_reg;

endmodule
